@@ rtl/core/tkf_pkg.sv @@
// Package for the two-axis tilt estimator: field widths, fixed-point
// formats, register reset values, register indexes and angle saturation.
// No dependencies.
`default_nettype none

package tkf_pkg;

   // field and register widths
   localparam int RATE_W      = 26;
   localparam int MEAS_W      = 24;
   localparam int ANGLE_W     = 32;
   localparam int VAR_W       = 32;
   localparam int OFFSET_W    = 26;
   localparam int STEP_W      = 17;
   localparam int QTERM_W     = 25;
   localparam int RVAR_W      = 32;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 3;

   // fixed-point formats
   localparam int STEP_FRAC = 16;
   localparam int VAR_FRAC  = 24;
   localparam int GAIN_W    = VAR_FRAC + 1;

   // datapath widths
   localparam int DRATE_W = RATE_W + 1;          // rate minus offset
   localparam int MUL_A_W = GAIN_W + 1;          // signed operand A
   localparam int MUL_B_W = VAR_W + 2;           // signed operand B
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int SUM_W   = 36;                  // angle sums before saturation
   localparam int DEN_W   = VAR_W + 1;
   localparam int REM_W   = VAR_W + 2;
   localparam int DIV_STEPS = GAIN_W;

   // register reset values
   localparam logic [STEP_W-1:0]  STEP_RESET  = STEP_W'(262);
   localparam logic [QTERM_W-1:0] QTERM_RESET = QTERM_W'(4295);
   localparam logic [RVAR_W-1:0]  RVAR_RESET  = RVAR_W'(150994944);
   localparam logic [VAR_W-1:0]   VAR_RESET   = VAR_W'(67108864);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROLL_OFFSET  = 3'd0,
      CSR_PITCH_OFFSET = 3'd1,
      CSR_STEP_TIME    = 3'd2,
      CSR_PROCESS_TERM = 3'd3,
      CSR_MEAS_VAR     = 3'd4
   } csr_index_type;

   function automatic logic signed [ANGLE_W-1:0] sat_angle(
      input logic signed [SUM_W-1:0] x
   );
      logic signed [ANGLE_W-1:0] r;
      if (x > 36'sh0_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (x < 36'shF_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = x[ANGLE_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/tilt_kalman_fusion.sv @@
// Two-axis tilt estimator (roll and pitch one-dimensional Kalman filters)
// on one shared multiplier and one restoring divider. Uses tkf_pkg.
`default_nettype none

// Usage
//   Request channel (req_*): one beat carries a roll and pitch gyro rate
//   (Q10.16 deg/s) and a roll and pitch accelerometer angle (Q8.16 deg).
//   Response channel (rsp_*): one beat per request with both filtered
//   angles, both variances (Q8.24) and the drive_forward bit (pitch > 0).
//   A beat moves at a rising edge with valid high and stall low.
//   Configuration (csr_*): write enable, register index and data; write
//   only while the block is idle. Unknown indexes are dropped.
// Sequencing
//   A taken request runs roll, then pitch, through prepare, rate step,
//   prediction, the bit-per-cycle gain divider, correction and variance;
//   three multiplies per axis share one registered multiplier. No new request
//   is taken until the result is in the response register; req_stall stays high while busy.
// Reset
//   Synchronous, active high: angles clear to zero, variances go to 4.0,
//   registers take their defaults, the response register empties.
// Receiver stall
//   The result waits in the response register; a finished next result
//   holds in the sequencer until that register is free, so nothing drops.
module tilt_kalman_fusion #(
   parameter int NUM_AXES = 2
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic signed [tkf_pkg::RATE_W-1:0]    req_roll_rate,
   input  wire logic signed [tkf_pkg::RATE_W-1:0]    req_pitch_rate,
   input  wire logic signed [tkf_pkg::MEAS_W-1:0]    req_roll_accel_angle,
   input  wire logic signed [tkf_pkg::MEAS_W-1:0]    req_pitch_accel_angle,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic signed [tkf_pkg::ANGLE_W-1:0]        rsp_roll_angle,
   output logic signed [tkf_pkg::ANGLE_W-1:0]        rsp_pitch_angle,
   output logic [tkf_pkg::VAR_W-1:0]                 rsp_roll_variance,
   output logic [tkf_pkg::VAR_W-1:0]                 rsp_pitch_variance,
   output logic                                      rsp_drive_forward,
   input  wire logic                                 csr_write_enable,
   input  wire logic [tkf_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [tkf_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   localparam int AXIS_W    = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
   localparam int LAST_AXIS = (NUM_AXES > 1) ? 1 : 0;
   localparam int CNT_W     = $clog2(tkf_pkg::DIV_STEPS);

   typedef enum logic [3:0] {
      S_IDLE, S_PREP, S_DELTA, S_PRED, S_DIV,
      S_CORR_MUL, S_CORR, S_VAR_MUL, S_VAR, S_OUT
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic signed [tkf_pkg::OFFSET_W-1:0] roll_off_ff, roll_off_in;
   logic signed [tkf_pkg::OFFSET_W-1:0] pitch_off_ff, pitch_off_in;
   logic [tkf_pkg::STEP_W-1:0]          step_ff, step_in;
   logic [tkf_pkg::QTERM_W-1:0]         qterm_ff, qterm_in;
   logic [tkf_pkg::RVAR_W-1:0]          rvar_ff, rvar_in;

   // captured request and filter state
   logic signed [tkf_pkg::DRATE_W-1:0] rate_ff [2];
   logic signed [tkf_pkg::DRATE_W-1:0] rate_in [2];
   logic signed [tkf_pkg::MEAS_W-1:0]  meas_ff [2];
   logic signed [tkf_pkg::MEAS_W-1:0]  meas_in [2];
   logic signed [tkf_pkg::ANGLE_W-1:0] angle_ff [NUM_AXES];
   logic signed [tkf_pkg::ANGLE_W-1:0] angle_in [NUM_AXES];
   logic [tkf_pkg::VAR_W-1:0]          var_ff [NUM_AXES];
   logic [tkf_pkg::VAR_W-1:0]          var_in [NUM_AXES];

   // sequencer working registers
   logic [AXIS_W-1:0]                  axis_ff, axis_in;
   logic [tkf_pkg::VAR_W-1:0]          psat_ff, psat_in;
   logic [tkf_pkg::DEN_W-1:0]          den_ff, den_in;
   logic signed [tkf_pkg::ANGLE_W-1:0] pred_ff, pred_in;
   logic [tkf_pkg::REM_W-1:0]          rem_ff, rem_in;
   logic [tkf_pkg::GAIN_W-1:0]         quo_ff, quo_in;
   logic [CNT_W-1:0]                   cnt_ff, cnt_in;
   logic signed [tkf_pkg::PROD_W-1:0]  prod_ff, prod_in;

   // response register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [tkf_pkg::ANGLE_W-1:0] roll_out_ff, roll_out_in;
   logic signed [tkf_pkg::ANGLE_W-1:0] pitch_out_ff, pitch_out_in;
   logic [tkf_pkg::VAR_W-1:0]          rvar_out_ff, rvar_out_in;
   logic [tkf_pkg::VAR_W-1:0]          pvar_out_ff, pvar_out_in;
   logic                               fwd_ff, fwd_in;

   // combinational helpers
   logic                               req_accept;
   logic                               pitch_sel;
   logic signed [tkf_pkg::DRATE_W-1:0] cur_rate;
   logic signed [tkf_pkg::MEAS_W-1:0]  cur_meas;
   logic signed [tkf_pkg::ANGLE_W-1:0] cur_angle;
   logic [tkf_pkg::VAR_W-1:0]          cur_var;
   logic [tkf_pkg::GAIN_W-1:0]         gain;
   logic signed [tkf_pkg::MUL_A_W-1:0] mul_a;
   logic signed [tkf_pkg::MUL_B_W-1:0] mul_b;
   logic signed [tkf_pkg::PROD_W-1:0]  rnd_step;
   logic signed [tkf_pkg::PROD_W-1:0]  rnd_var;
   logic signed [tkf_pkg::SUM_W-1:0]   pred_sum;
   logic signed [tkf_pkg::SUM_W-1:0]   corr_sum;
   logic [tkf_pkg::DEN_W-1:0]          p_sum;
   logic [tkf_pkg::VAR_W-1:0]          p_sat;
   logic [tkf_pkg::REM_W-1:0]          trial;
   logic                               trial_ge;
   logic signed [tkf_pkg::ANGLE_W-1:0] pitch_angle_w;
   logic [tkf_pkg::VAR_W-1:0]          pitch_var_w;

   // Pitch result exists only when the pitch axis is built.
   if (NUM_AXES > 1) begin : g_pitch
      assign pitch_angle_w = angle_ff[1];
      assign pitch_var_w   = var_ff[1];
   end else begin : g_no_pitch
      assign pitch_angle_w = '0;
      assign pitch_var_w   = '0;
   end

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;

   assign pitch_sel = (axis_ff == AXIS_W'(1));
   assign cur_rate  = pitch_sel ? rate_ff[1] : rate_ff[0];
   assign cur_meas  = pitch_sel ? meas_ff[1] : meas_ff[0];
   assign cur_angle = angle_ff[axis_ff];
   assign cur_var   = var_ff[axis_ff];

   // A zero denominator forces a zero gain.
   assign gain = (den_ff == '0) ? '0 : quo_ff;

   // Predicted variance, saturated; S_PREP adds R to it for the gain denominator.
   assign p_sum = {1'b0, cur_var} + tkf_pkg::DEN_W'(qterm_ff);
   assign p_sat = p_sum[tkf_pkg::VAR_W] ? '1 : p_sum[tkf_pkg::VAR_W-1:0];

   // Shared multiplier operand selection.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_DELTA: begin
            mul_a = tkf_pkg::MUL_A_W'(step_ff);
            mul_b = tkf_pkg::MUL_B_W'(cur_rate);
         end
         S_CORR_MUL: begin
            mul_a = tkf_pkg::MUL_A_W'(gain);
            mul_b = tkf_pkg::MUL_B_W'(cur_meas) - tkf_pkg::MUL_B_W'(pred_ff);
         end
         S_VAR_MUL: begin
            mul_a = tkf_pkg::MUL_A_W'(tkf_pkg::GAIN_W'(1 << tkf_pkg::VAR_FRAC) - gain);
            mul_b = tkf_pkg::MUL_B_W'(psat_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // Round to nearest, ties up; the part-select is a floor shift.
   assign rnd_step = prod_ff + tkf_pkg::PROD_W'(1 << (tkf_pkg::STEP_FRAC - 1));
   assign rnd_var  = prod_ff + tkf_pkg::PROD_W'(1 << (tkf_pkg::VAR_FRAC - 1));
   assign pred_sum = tkf_pkg::SUM_W'(cur_angle)
                   + rnd_step[tkf_pkg::STEP_FRAC +: tkf_pkg::SUM_W];
   assign corr_sum = tkf_pkg::SUM_W'(pred_ff)
                   + rnd_var[tkf_pkg::VAR_FRAC +: tkf_pkg::SUM_W];

   // One restoring divide step: first step compares the plain dividend.
   assign trial    = (cnt_ff == '0) ? rem_ff : {rem_ff[tkf_pkg::REM_W-2:0], 1'b0};
   assign trial_ge = (trial >= tkf_pkg::REM_W'(den_ff));

   always_comb begin
      state_in     = state_ff;
      roll_off_in  = roll_off_ff;
      pitch_off_in = pitch_off_ff;
      step_in      = step_ff;
      qterm_in     = qterm_ff;
      rvar_in      = rvar_ff;
      rate_in      = rate_ff;
      meas_in      = meas_ff;
      angle_in     = angle_ff;
      var_in       = var_ff;
      axis_in      = axis_ff;
      psat_in      = psat_ff;
      den_in       = den_ff;
      pred_in      = pred_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      roll_out_in  = roll_out_ff;
      pitch_out_in = pitch_out_ff;
      rvar_out_in  = rvar_out_ff;
      pvar_out_in  = pvar_out_ff;
      fwd_in       = fwd_ff;

      if (csr_write_enable) begin
         unique case (csr_index)
            tkf_pkg::CSR_ROLL_OFFSET:
               roll_off_in = csr_write_data[tkf_pkg::OFFSET_W-1:0];
            tkf_pkg::CSR_PITCH_OFFSET:
               pitch_off_in = csr_write_data[tkf_pkg::OFFSET_W-1:0];
            tkf_pkg::CSR_STEP_TIME:
               step_in = csr_write_data[tkf_pkg::STEP_W-1:0];
            tkf_pkg::CSR_PROCESS_TERM:
               qterm_in = csr_write_data[tkf_pkg::QTERM_W-1:0];
            tkf_pkg::CSR_MEAS_VAR:
               rvar_in = csr_write_data[tkf_pkg::RVAR_W-1:0];
            default: ;
         endcase
      end

      // drop the response once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               rate_in[0] = tkf_pkg::DRATE_W'(req_roll_rate)
                          - tkf_pkg::DRATE_W'(roll_off_ff);
               rate_in[1] = tkf_pkg::DRATE_W'(req_pitch_rate)
                          - tkf_pkg::DRATE_W'(pitch_off_ff);
               meas_in[0] = req_roll_accel_angle;
               meas_in[1] = req_pitch_accel_angle;
               axis_in    = '0;
               state_in   = S_PREP;
            end
         end
         S_PREP: begin
            psat_in  = p_sat;
            den_in   = tkf_pkg::DEN_W'(p_sat) + tkf_pkg::DEN_W'(rvar_ff);
            state_in = S_DELTA;
         end
         S_DELTA: begin
            state_in = S_PRED;
         end
         S_PRED: begin
            pred_in  = tkf_pkg::sat_angle(pred_sum);
            rem_in   = tkf_pkg::REM_W'(psat_ff);
            quo_in   = '0;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in = trial_ge ? (trial - tkf_pkg::REM_W'(den_ff)) : trial;
            quo_in = {quo_ff[tkf_pkg::GAIN_W-2:0], trial_ge};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(tkf_pkg::DIV_STEPS - 1)) begin
               state_in = S_CORR_MUL;
            end
         end
         S_CORR_MUL: begin
            state_in = S_CORR;
         end
         S_CORR: begin
            angle_in[axis_ff] = tkf_pkg::sat_angle(corr_sum);
            state_in          = S_VAR_MUL;
         end
         S_VAR_MUL: begin
            state_in = S_VAR;
         end
         S_VAR: begin
            var_in[axis_ff] = rnd_var[tkf_pkg::VAR_FRAC +: tkf_pkg::VAR_W];
            if (axis_ff == AXIS_W'(LAST_AXIS)) begin
               state_in = S_OUT;
            end else begin
               axis_in  = axis_ff + AXIS_W'(1);
               state_in = S_PREP;
            end
         end
         S_OUT: begin
            // hold until the response register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               roll_out_in  = angle_ff[0];
               pitch_out_in = pitch_angle_w;
               rvar_out_in  = var_ff[0];
               pvar_out_in  = pitch_var_w;
               fwd_in       = (pitch_angle_w > 32'sd0);
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         roll_off_ff  <= '0;
         pitch_off_ff <= '0;
         step_ff      <= tkf_pkg::STEP_RESET;
         qterm_ff     <= tkf_pkg::QTERM_RESET;
         rvar_ff      <= tkf_pkg::RVAR_RESET;
         for (int i = 0; i < NUM_AXES; i++) begin
            angle_ff[i] <= '0;
            var_ff[i]   <= tkf_pkg::VAR_RESET;
         end
         axis_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         roll_off_ff  <= roll_off_in;
         pitch_off_ff <= pitch_off_in;
         step_ff      <= step_in;
         qterm_ff     <= qterm_in;
         rvar_ff      <= rvar_in;
         angle_ff     <= angle_in;
         var_ff       <= var_in;
         axis_ff      <= axis_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      // payload registers
      rate_ff      <= rate_in;
      meas_ff      <= meas_in;
      psat_ff      <= psat_in;
      den_ff       <= den_in;
      pred_ff      <= pred_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      prod_ff      <= prod_in;
      roll_out_ff  <= roll_out_in;
      pitch_out_ff <= pitch_out_in;
      rvar_out_ff  <= rvar_out_in;
      pvar_out_ff  <= pvar_out_in;
      fwd_ff       <= fwd_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_roll_angle     = roll_out_ff;
   assign rsp_pitch_angle    = pitch_out_ff;
   assign rsp_roll_variance  = rvar_out_ff;
   assign rsp_pitch_variance = pvar_out_ff;
   assign rsp_drive_forward  = fwd_ff;

endmodule

`default_nettype wire

@@ test/tb_tilt_kalman_fusion.sv @@
// Self-checking bench for the two-axis tilt estimator: a queued beat driver,
// a response monitor and a cycle-free Kalman predictor for both axes.
// Depends on tkf_pkg and tilt_kalman_fusion.
`timescale 1ns / 100ps

module tb_tilt_kalman_fusion;

   localparam int RESET_CYCLES  = 9;
   localparam int SETTLE_CYCLES = 80;     // outlasts the latency of one item
   localparam int REPORT_LIMIT  = 10;
   localparam int PHASE_ITEMS   = 75;
   localparam int RANDOM_PHASES = 12;
   localparam int RUN_LIMIT_NS  = 2_000_000;

   // indexes with no register behind them
   localparam logic [tkf_pkg::CSR_INDEX_W-1:0] CSR_SPARE_LOW  = 3'd5;
   localparam logic [tkf_pkg::CSR_INDEX_W-1:0] CSR_SPARE_HIGH = 3'd7;

   localparam int RATE_SPAN   = 32768000;   // 500 deg/s in Q10.16
   localparam int RATE_TOP    = 33554431;   // widest values of a 26-bit field
   localparam int RATE_BOTTOM = -33554432;
   localparam int MEAS_SPAN   = 5898240;    // 90 deg in Q8.16
   localparam int MEAS_TOP    = 8388607;    // widest values of a 24-bit field
   localparam int MEAS_BOTTOM = -8388608;

   localparam longint ANGLE_HI = 64'sd2147483647;
   localparam longint ANGLE_LO = -64'sd2147483648;
   localparam longint VAR_CEIL = 64'sh0000_0000_FFFF_FFFF;
   localparam longint GAIN_ONE = 64'sd1 <<< tkf_pkg::VAR_FRAC;

   typedef enum {MIX_TYPICAL, MIX_WIDE, MIX_RISE, MIX_FALL} sample_mix_type;
   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct {
      logic signed [tkf_pkg::RATE_W-1:0] roll_rate;
      logic signed [tkf_pkg::RATE_W-1:0] pitch_rate;
      logic signed [tkf_pkg::MEAS_W-1:0] roll_accel;
      logic signed [tkf_pkg::MEAS_W-1:0] pitch_accel;
   } tilt_sample_type;

   typedef struct {
      logic signed [tkf_pkg::ANGLE_W-1:0] roll_angle;
      logic signed [tkf_pkg::ANGLE_W-1:0] pitch_angle;
      logic [tkf_pkg::VAR_W-1:0]          roll_variance;
      logic [tkf_pkg::VAR_W-1:0]          pitch_variance;
      logic                               drive_forward;
   } tilt_estimate_type;

   // ---------------------------------------------------------------------
   // Block ports; every input starts at a known value
   // ---------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic signed [tkf_pkg::RATE_W-1:0]   req_roll_rate = '0;
   logic signed [tkf_pkg::RATE_W-1:0]   req_pitch_rate = '0;
   logic signed [tkf_pkg::MEAS_W-1:0]   req_roll_accel_angle = '0;
   logic signed [tkf_pkg::MEAS_W-1:0]   req_pitch_accel_angle = '0;

   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic signed [tkf_pkg::ANGLE_W-1:0]  rsp_roll_angle;
   logic signed [tkf_pkg::ANGLE_W-1:0]  rsp_pitch_angle;
   logic [tkf_pkg::VAR_W-1:0]           rsp_roll_variance;
   logic [tkf_pkg::VAR_W-1:0]           rsp_pitch_variance;
   logic                                rsp_drive_forward;

   logic                                csr_write_enable = 1'b0;
   logic [tkf_pkg::CSR_INDEX_W-1:0]     csr_index = '0;
   logic [tkf_pkg::CSR_DATA_W-1:0]      csr_write_data = '0;

   tilt_kalman_fusion dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_roll_rate         (req_roll_rate),
      .req_pitch_rate        (req_pitch_rate),
      .req_roll_accel_angle  (req_roll_accel_angle),
      .req_pitch_accel_angle (req_pitch_accel_angle),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_roll_angle        (rsp_roll_angle),
      .rsp_pitch_angle       (rsp_pitch_angle),
      .rsp_roll_variance     (rsp_roll_variance),
      .rsp_pitch_variance    (rsp_pitch_variance),
      .rsp_drive_forward     (rsp_drive_forward),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------
   // Bench state
   // ---------------------------------------------------------------------
   tilt_sample_type   queued_samples[$];     // beats still to be offered
   tilt_estimate_type awaited_estimates[$];  // predictions of accepted beats, oldest first
   tilt_sample_type   beat_on_bus;           // beat currently presented on req_*

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int gap_left       = 0;
   int mismatch_count = 0;

   // predictor copy of the filter state and the registers
   longint angle_est[2];
   longint var_est[2];
   longint rate_bias[2];
   longint dt_q16;
   longint q_term;
   longint r_var;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   function automatic longint clip_angle(longint x);
      if (x > ANGLE_HI) begin
         return ANGLE_HI;
      end
      if (x < ANGLE_LO) begin
         return ANGLE_LO;
      end
      return x;
   endfunction

   // One predict/update step of a single axis, rounding half toward +inf
   // on the rate step, the correction and the new variance.
   function automatic void filter_axis(int a, longint rate, longint meas);
      longint delta, pred, p, den, gain, corr;
      delta = (dt_q16 * rate + (64'sd1 <<< (tkf_pkg::STEP_FRAC - 1)))
              >>> tkf_pkg::STEP_FRAC;
      pred  = clip_angle(angle_est[a] + delta);
      p = var_est[a] + q_term;
      if (p > VAR_CEIL) begin
         p = VAR_CEIL;                       // variance saturates
      end
      den  = p + r_var;
      // zero denominator: no update
      gain = (den != 0) ? (p <<< tkf_pkg::VAR_FRAC) / den : 64'sd0;
      corr = (gain * (meas - pred) + (64'sd1 <<< (tkf_pkg::VAR_FRAC - 1)))
             >>> tkf_pkg::VAR_FRAC;
      angle_est[a] = clip_angle(pred + corr);
      var_est[a] = (((GAIN_ONE - gain) * p + (64'sd1 <<< (tkf_pkg::VAR_FRAC - 1)))
                    >>> tkf_pkg::VAR_FRAC) & VAR_CEIL;
   endfunction

   function automatic tilt_estimate_type kalman_predict(tilt_sample_type s);
      tilt_estimate_type e;
      filter_axis(0, longint'(s.roll_rate) - rate_bias[0], longint'(s.roll_accel));
      filter_axis(1, longint'(s.pitch_rate) - rate_bias[1], longint'(s.pitch_accel));
      e.roll_angle     = angle_est[0][tkf_pkg::ANGLE_W-1:0];
      e.pitch_angle    = angle_est[1][tkf_pkg::ANGLE_W-1:0];
      e.roll_variance  = var_est[0][tkf_pkg::VAR_W-1:0];
      e.pitch_variance = var_est[1][tkf_pkg::VAR_W-1:0];
      e.drive_forward  = (angle_est[1] > 0);
      return e;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic logic signed [tkf_pkg::RATE_W-1:0] rate_pick(sample_mix_type mix);
      int r;
      case (mix)
         MIX_WIDE: r = int'($urandom());
         MIX_RISE: r = int'($urandom_range(RATE_SPAN, RATE_SPAN / 2));
         MIX_FALL: r = -int'($urandom_range(RATE_SPAN, RATE_SPAN / 2));
         default: begin
            if ($urandom_range(3) == 0) begin
               r = int'($urandom_range(2 * 655360)) - 655360;   // within +-10 deg/s
            end else begin
               r = int'($urandom_range(2 * RATE_SPAN)) - RATE_SPAN;
            end
         end
      endcase
      return r[tkf_pkg::RATE_W-1:0];
   endfunction

   function automatic logic signed [tkf_pkg::MEAS_W-1:0] accel_pick(sample_mix_type mix);
      int r;
      if (mix == MIX_WIDE) begin
         r = int'($urandom());
      end else begin
         r = int'($urandom_range(2 * MEAS_SPAN)) - MEAS_SPAN;
      end
      return r[tkf_pkg::MEAS_W-1:0];
   endfunction

   task automatic push_random(sample_mix_type mix);
      tilt_sample_type s;
      sample_mix_type  m;
      // a fifth of the beats are raw noise over the full field widths
      m = ($urandom_range(4) == 0) ? MIX_WIDE : mix;
      s.roll_rate   = rate_pick(m);
      s.pitch_rate  = rate_pick(m);
      s.roll_accel  = accel_pick(m);
      s.pitch_accel = accel_pick(m);
      queued_samples.push_back(s);
   endtask

   task automatic push_sample(int rr, int pr, int ra, int pa);
      tilt_sample_type s;
      s.roll_rate   = rr[tkf_pkg::RATE_W-1:0];
      s.pitch_rate  = pr[tkf_pkg::RATE_W-1:0];
      s.roll_accel  = ra[tkf_pkg::MEAS_W-1:0];
      s.pitch_accel = pa[tkf_pkg::MEAS_W-1:0];
      queued_samples.push_back(s);
   endtask

   // Hold until every queued beat went out and every estimate came back;
   // look at the falling edge so the driver's updates have settled.
   task automatic wait_drained();
      while (queued_samples.size() != 0 || req_valid || awaited_estimates.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Write one register while idle and mirror it into the predictor.
   task automatic write_register(logic [tkf_pkg::CSR_INDEX_W-1:0] index,
                                 logic [tkf_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (index)
         tkf_pkg::CSR_ROLL_OFFSET:
            rate_bias[0] = longint'($signed(data[tkf_pkg::OFFSET_W-1:0]));
         tkf_pkg::CSR_PITCH_OFFSET:
            rate_bias[1] = longint'($signed(data[tkf_pkg::OFFSET_W-1:0]));
         tkf_pkg::CSR_STEP_TIME:    dt_q16 = longint'(data[tkf_pkg::STEP_W-1:0]);
         tkf_pkg::CSR_PROCESS_TERM: q_term = longint'(data[tkf_pkg::QTERM_W-1:0]);
         tkf_pkg::CSR_MEAS_VAR:     r_var  = longint'(data[tkf_pkg::RVAR_W-1:0]);
         default: ;        // unknown index: the block drops it
      endcase
   endtask

   task automatic set_idling(idle_mode_type mode);
      case (mode)
         IDLE_SENDER:   begin send_idle_pct = 63; recv_stall_pct = 0;  end
         IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 63; end
         IDLE_BOTH:     begin send_idle_pct = 16; recv_stall_pct = 16; end
         default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
   endtask

   task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Driver: offer queued beats on req_*, hold a stalled beat unchanged,
   // and predict each beat at the edge where it is taken.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            awaited_estimates.push_back(kalman_predict(beat_on_bus));
         end
         // bus free (nothing offered, or the offered beat just went): refill or idle
         if (!req_valid || !req_stall) begin
            if (queued_samples.size() == 0) begin
               req_valid <= 1'b0;
            end else if (gap_left > 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if ($urandom_range(99) < send_idle_pct) begin
               req_valid <= 1'b0;
               // now and then stretch the gap across the block's busy window
               if ($urandom_range(7) == 0) begin
                  gap_left <= $urandom_range(80);
               end
            end else begin
               beat_on_bus = queued_samples.pop_front();
               req_roll_rate         <= beat_on_bus.roll_rate;
               req_pitch_rate        <= beat_on_bus.pitch_rate;
               req_roll_accel_angle  <= beat_on_bus.roll_accel;
               req_pitch_accel_angle <= beat_on_bus.pitch_accel;
               req_valid             <= 1'b1;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: take a response beat when valid and not stalled, check it
   // against the oldest estimate, then pick the next stall level.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      tilt_estimate_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_estimates.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("%0t: response beat with no request pending", $realtime);
               end
            end else begin
               want = awaited_estimates.pop_front();
               compare_field("roll_angle", want.roll_angle, rsp_roll_angle);
               compare_field("pitch_angle", want.pitch_angle, rsp_pitch_angle);
               compare_field("roll_variance", want.roll_variance, rsp_roll_variance);
               compare_field("pitch_variance", want.pitch_variance, rsp_pitch_variance);
               compare_field("drive_forward", 32'(want.drive_forward), 32'(rsp_drive_forward));
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Sequence: directed corners, then random phases with fresh registers
   // ---------------------------------------------------------------------
   initial begin : sequence_flow
      logic [tkf_pkg::CSR_DATA_W-1:0] value;
      sample_mix_type                 mix;

      // mirror the reset state
      for (int a = 0; a < 2; a++) begin
         angle_est[a] = 0;
         var_est[a]   = longint'(tkf_pkg::VAR_RESET);
         rate_bias[a] = 0;
      end
      dt_q16 = longint'(tkf_pkg::STEP_RESET);
      q_term = longint'(tkf_pkg::QTERM_RESET);
      r_var  = longint'(tkf_pkg::RVAR_RESET);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // field extremes under the reset registers
      set_idling(IDLE_NONE);
      push_sample(0, 0, 0, 0);
      push_sample(RATE_TOP, RATE_TOP, MEAS_SPAN, MEAS_SPAN);
      push_sample(RATE_BOTTOM, RATE_BOTTOM, -MEAS_SPAN, -MEAS_SPAN);
      push_sample(RATE_SPAN, -RATE_SPAN, MEAS_TOP, MEAS_BOTTOM);
      wait_drained();

      // unknown indexes are dropped; step time zero means no rate step
      write_register(CSR_SPARE_LOW, 32'hFFFF_FFFF);
      write_register(CSR_SPARE_HIGH, 32'h0000_0000);
      write_register(tkf_pkg::CSR_STEP_TIME, 32'd0);
      push_sample(RATE_TOP, RATE_BOTTOM, MEAS_BOTTOM, MEAS_TOP);
      wait_drained();

      // R = 0 and no process term: the first beat collapses P to zero,
      // the next one sees a zero denominator
      write_register(tkf_pkg::CSR_MEAS_VAR, 32'd0);
      write_register(tkf_pkg::CSR_PROCESS_TERM, 32'd0);
      push_sample(RATE_SPAN, RATE_SPAN, 65536, -65536);
      push_sample(-RATE_SPAN, RATE_SPAN, MEAS_SPAN, -MEAS_SPAN);
      wait_drained();

      // angle overflow: widest biases and step with P at zero integrate
      // the rates until both angles clip, roll high and pitch low
      write_register(tkf_pkg::CSR_ROLL_OFFSET, RATE_BOTTOM);
      write_register(tkf_pkg::CSR_PITCH_OFFSET, RATE_TOP);
      write_register(tkf_pkg::CSR_STEP_TIME, 32'd131071);
      write_register(tkf_pkg::CSR_MEAS_VAR, 32'hFFFF_FFFF);
      repeat (18) push_sample(RATE_TOP, RATE_BOTTOM, 0, 0);
      wait_drained();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         mix = MIX_TYPICAL;
         if (ph == 3 || ph == 7) begin
            // drift phases: long step, no process noise, huge R, so the
            // estimate runs into its clipping limit
            mix = (ph == 3) ? MIX_FALL : MIX_RISE;
            write_register(tkf_pkg::CSR_ROLL_OFFSET, 32'd0);
            write_register(tkf_pkg::CSR_PITCH_OFFSET, 32'd0);
            write_register(tkf_pkg::CSR_STEP_TIME, 32'd131071);
            write_register(tkf_pkg::CSR_PROCESS_TERM, 32'd0);
            write_register(tkf_pkg::CSR_MEAS_VAR, 32'hFFFF_FFFF);
         end else begin
            for (int r = 0; r < 5; r++) begin
               case ($urandom_range(7))
                  0: value = 32'd0;
                  1: value = 32'd1;
                  2: value = 32'hFFFF_FFFF;           // masked to the register width
                  3: value = $urandom();
                  default: begin
                     case (r)
                        tkf_pkg::CSR_ROLL_OFFSET, tkf_pkg::CSR_PITCH_OFFSET:
                           value = 32'($urandom_range(2 * RATE_SPAN)) - 32'(RATE_SPAN);
                        tkf_pkg::CSR_STEP_TIME:    value = $urandom_range(65536, 1);
                        tkf_pkg::CSR_PROCESS_TERM: value = $urandom_range(16777216);
                        default:                   value = $urandom_range(32'hFFFF_FFFF, 1);
                     endcase
                  end
               endcase
               if (r < 2 && $urandom_range(5) == 0) begin
                  value = ($urandom_range(1) == 0) ? RATE_TOP : RATE_BOTTOM;
               end
               write_register(r[tkf_pkg::CSR_INDEX_W-1:0], value);
            end
         end
         set_idling(idle_mode_type'(ph % 4));
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            push_random(mix);
            // once, halt the sender mid-phase until the pipe is empty
            if (ph == 5 && i == PHASE_ITEMS / 2) begin
               wait_drained();
            end
         end
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && awaited_estimates.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #RUN_LIMIT_NS;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
